>>> rtl/core/fixed_point_triangle_span_generator_assert.svh
// Assertion macros used by the span generator checker.
// No dependencies; included by the checker file.
`ifndef FIXED_POINT_TRIANGLE_SPAN_GENERATOR_ASSERT_SVH
`define FIXED_POINT_TRIANGLE_SPAN_GENERATOR_ASSERT_SVH

// Generic clocked assertion, disabled while the active-low reset is low.
`define FPTSG_ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: assertion failed");

// Assertion on the block clock and reset.
`define FPTSG_ASSERT(label, prop) \
    `FPTSG_ASSERT_CLK(label, aclk, aresetn, prop)

`endif

>>> rtl/core/fptsg_pkg.sv
// Shared types and constants for the triangle span generator.
// No dependencies.
package fptsg_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;
    localparam int EDGE_W     = 32;
    localparam int CLIP_W     = 11;
    localparam int WORD_W     = 32;
    localparam int PITCH_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int DIV_W      = COORD_BITS + FRAC_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [COORD_BITS:0]   diff_t;
    typedef logic signed [EDGE_W-1:0]     edge_t;
    typedef logic signed [EDGE_W:0]       sx_t;
    typedef logic [CLIP_W-1:0]            clip_t;
    typedef logic [WORD_W-1:0]            word_t;
    typedef logic [PITCH_W-1:0]           pitch_t;

    localparam sx_t ROUND_HALF = sx_t'(1) <<< (FRAC_BITS - 1);

    typedef enum logic [1:0] {
        STATUS_IDLE     = 2'd0,
        STATUS_ACCEPTED = 2'd1,
        STATUS_NOTHING  = 2'd2,
        STATUS_SPAN     = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLIP_MIN_X = 3'd0,
        CFG_CLIP_MAX_X = 3'd1,
        CFG_CLIP_MIN_Y = 3'd2,
        CFG_CLIP_MAX_Y = 3'd3,
        CFG_FRAME_BASE = 3'd4,
        CFG_LINE_PITCH = 3'd5
    } cfg_reg_t;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_SPAN = 1'b1;

    typedef enum logic [1:0] {
        KIND_FLAT_TOP,
        KIND_FLAT_BOTTOM,
        KIND_GENERAL
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_L,
        S_WAIT_L,
        S_DIV_R,
        S_WAIT_R,
        S_MUL_L,
        S_ADD_L,
        S_MUL_R,
        S_ADD_R,
        S_MUL_A,
        S_FINISH,
        S_REST_DIV,
        S_REST_WAIT,
        S_RESP
    } state_t;

    typedef struct packed {
        logic   command;
        coord_t vert_a_x;
        coord_t vert_a_y;
        coord_t vert_b_x;
        coord_t vert_b_y;
        coord_t vert_c_x;
        coord_t vert_c_y;
        word_t  fill_color;
    } in_item_t;

    typedef struct packed {
        status_t status;
        coord_t  span_y;
        coord_t  x_start;
        coord_t  x_end;
        word_t   row_address;
        word_t   span_color;
        logic    last_span;
    } out_item_t;

    // Divider request and response
    typedef struct packed {
        logic  start;
        diff_t dx;
        diff_t dy;
    } div_req_t;

    typedef struct packed {
        logic  done;
        edge_t quo;
    } div_rsp_t;

endpackage

>>> rtl/core/fptsg_divider.sv
// Bit-serial truncating divider: (dx << FRAC_BITS) / dy, zero when dy <= 0.
// Depends on fptsg_pkg.
module fptsg_divider (
    input  logic                aclk,
    input  logic                aresetn,
    input  fptsg_pkg::div_req_t req,
    output fptsg_pkg::div_rsp_t rsp
);
    import fptsg_pkg::*;

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIV_W-1:0]       num_reg, num_next;
    logic [COORD_BITS-1:0]  rem_reg, rem_next;
    logic [COORD_BITS-1:0]  den_reg, den_next;
    logic                   neg_reg, neg_next;
    logic                   zero_reg, zero_next;
    logic [COORD_BITS:0]    trial;
    logic [COORD_BITS:0]    trial_sub;
    logic [COORD_BITS-1:0]  mag;
    edge_t                  quo_mag;

    // One quotient bit per cycle, restoring form
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        mag       = req.dx[COORD_BITS] ? COORD_BITS'(-req.dx) : req.dx[COORD_BITS-1:0];
        trial     = {rem_reg, num_reg[DIV_W-1]};
        trial_sub = trial - {1'b0, den_reg};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_W);
            num_next  = {mag, {FRAC_BITS{1'b0}}};
            rem_next  = '0;
            den_next  = req.dy[COORD_BITS-1:0];
            neg_next  = req.dx[COORD_BITS];
            zero_next = (req.dy <= 0);
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = trial_sub[COORD_BITS-1:0];
                num_next = {num_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = trial[COORD_BITS-1:0];
                num_next = {num_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

    // Sign and zero fix-up of the quotient
    always_comb begin
        quo_mag  = edge_t'(num_reg);
        rsp.done = done_reg;
        if (zero_reg) begin
            rsp.quo = '0;
        end else if (neg_reg) begin
            rsp.quo = -quo_mag;
        end else begin
            rsp.quo = quo_mag;
        end
    end

endmodule

>>> rtl/core/fixed_point_triangle_span_generator.sv
// Top level of the flat-shaded triangle span generator.
// Depends on fptsg_pkg and fptsg_divider.
//
// Usage:
//   s_* channel takes requests: command 0 loads a triangle (three integer
//   vertices and a color), command 1 asks for the next span.
//   m_* channel returns exactly one result per request: load status
//   (accepted or nothing to draw), a span, or idle for a span request
//   with no active triangle.
//   cfg_* channel writes clip rectangle, frame base and line pitch; it is
//   always ready and should only be written while the block is idle.
// Request flow:
//   One request at a time; s_ready is low from acceptance until the result
//   is taken. A rejected load goes straight to its result. An accepted load
//   runs two slope divisions in the shared bit-serial divider (one quotient
//   bit a cycle) and three passes through the shared multiplier. A span
//   request emits its span; the span on the middle vertex line also waits
//   for the divider to compute the new edge slope.
// Reset clears all control state and the clip registers to 0/639/0/479.
// A stalled receiver holds the result in the output register; no new
// request is taken until it drains.
module fixed_point_triangle_span_generator (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  fptsg_pkg::in_item_t         s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output fptsg_pkg::out_item_t        m_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [fptsg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fptsg_pkg::WORD_W-1:0]    cfg_data
);
    import fptsg_pkg::*;

    function automatic diff_t clip_ext(input clip_t v);
        return diff_t'({1'b0, v});
    endfunction

    function automatic edge_t fix(input coord_t v);
        return edge_t'(v) <<< FRAC_BITS;
    endfunction

    // Configuration registers
    clip_t  clip_min_x_reg, clip_max_x_reg, clip_min_y_reg, clip_max_y_reg;
    word_t  frame_base_reg;
    pitch_t line_pitch_reg;

    // Triangle state
    state_t    state_reg, state_next;
    coord_t    sx_reg[3], sx_next[3];
    coord_t    sy_reg[3], sy_next[3];
    kind_t     kind_reg, kind_next;
    word_t     color_reg, color_next;
    edge_t     edge_l_reg, edge_l_next, edge_r_reg, edge_r_next;
    edge_t     slope_l_reg, slope_l_next, slope_r_reg, slope_r_next;
    coord_t    cur_line_reg, cur_line_next;
    coord_t    end_line_reg, end_line_next;
    logic      right_reg, right_next;
    logic      armed_reg, armed_next;
    logic      busy_reg, busy_next;
    word_t     line_addr_reg, line_addr_next;
    edge_t     prod_reg, prod_next;
    out_item_t result_reg, result_next;

    div_req_t  div_req;
    div_rsp_t  div_rsp;

    // Setup terms derived from the sorted vertices
    diff_t     mny, mxy;
    logic      general, y1_clip, y0_clip;
    diff_t     dx_l, dy_l, dx_r, dy_r, dd_l, dd_r;
    coord_t    base_l, base_r, ys;
    logic [COORD_BITS-1:0] d_l, d_r;
    logic      swap;

    // Sort and reject terms from the incoming request
    coord_t    vx[3], vy[3];
    coord_t    tx, ty;
    diff_t     mnx_in, mxx_in;
    logic      reject, degenerate;
    kind_t     kind_in;

    // Span terms
    sx_t       sum_l, sum_r, xs, xe;
    diff_t     next_line;

    // Shared multiplier
    edge_t                   mul_a;
    logic [COORD_BITS-1:0]   mul_b;
    logic signed [EDGE_W+COORD_BITS:0] mul_full;

    fptsg_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_min_x_reg <= clip_t'(0);
            clip_max_x_reg <= clip_t'(639);
            clip_min_y_reg <= clip_t'(0);
            clip_max_y_reg <= clip_t'(479);
            frame_base_reg <= '0;
            line_pitch_reg <= pitch_t'(640);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                CFG_CLIP_MIN_X: clip_min_x_reg <= cfg_data[CLIP_W-1:0];
                CFG_CLIP_MAX_X: clip_max_x_reg <= cfg_data[CLIP_W-1:0];
                CFG_CLIP_MIN_Y: clip_min_y_reg <= cfg_data[CLIP_W-1:0];
                CFG_CLIP_MAX_Y: clip_max_y_reg <= cfg_data[CLIP_W-1:0];
                CFG_FRAME_BASE: frame_base_reg <= cfg_data;
                CFG_LINE_PITCH: line_pitch_reg <= cfg_data[PITCH_W-1:0];
                default: ;
            endcase
        end
    end

    // Trivial reject, sort by y, classify
    always_comb begin
        vx[0] = s_data.vert_a_x; vy[0] = s_data.vert_a_y;
        vx[1] = s_data.vert_b_x; vy[1] = s_data.vert_b_y;
        vx[2] = s_data.vert_c_x; vy[2] = s_data.vert_c_y;
        mnx_in = clip_ext(clip_min_x_reg);
        mxx_in = clip_ext(clip_max_x_reg);
        reject = (diff_t'(vy[0]) < mny && diff_t'(vy[1]) < mny && diff_t'(vy[2]) < mny) ||
                 (diff_t'(vy[0]) > mxy && diff_t'(vy[1]) > mxy && diff_t'(vy[2]) > mxy) ||
                 (diff_t'(vx[0]) < mnx_in && diff_t'(vx[1]) < mnx_in &&
                  diff_t'(vx[2]) < mnx_in) ||
                 (diff_t'(vx[0]) > mxx_in && diff_t'(vx[1]) > mxx_in &&
                  diff_t'(vx[2]) > mxx_in);
        degenerate = (vx[0] == vx[1] && vx[1] == vx[2]) ||
                     (vy[0] == vy[1] && vy[1] == vy[2]);
        if (vy[1] < vy[0]) begin
            tx = vx[0]; ty = vy[0]; vx[0] = vx[1]; vy[0] = vy[1]; vx[1] = tx; vy[1] = ty;
        end
        if (vy[2] < vy[0]) begin
            tx = vx[0]; ty = vy[0]; vx[0] = vx[2]; vy[0] = vy[2]; vx[2] = tx; vy[2] = ty;
        end
        if (vy[2] < vy[1]) begin
            tx = vx[1]; ty = vy[1]; vx[1] = vx[2]; vy[1] = vy[2]; vx[2] = tx; vy[2] = ty;
        end
        tx = vx[0]; ty = vy[0];
        if (vy[0] == vy[1]) begin
            kind_in = KIND_FLAT_TOP;
            if (vx[1] < vx[0]) begin
                tx = vx[0]; vx[0] = vx[1]; vx[1] = tx;
            end
        end else if (vy[1] == vy[2]) begin
            kind_in = KIND_FLAT_BOTTOM;
            if (vx[2] < vx[1]) begin
                tx = vx[1]; vx[1] = vx[2]; vx[2] = tx;
            end
        end else begin
            kind_in = KIND_GENERAL;
        end
    end

    // Edge setup terms
    always_comb begin
        mny     = clip_ext(clip_min_y_reg);
        mxy     = clip_ext(clip_max_y_reg);
        general = (kind_reg == KIND_GENERAL);
        y0_clip = diff_t'(sy_reg[0]) < mny;
        y1_clip = diff_t'(sy_reg[1]) < mny;
        dd_l    = y0_clip ? mny - diff_t'(sy_reg[0]) : '0;
        dd_r    = dd_l;
        base_l  = sx_reg[0];
        base_r  = sx_reg[0];
        dx_l    = diff_t'(sx_reg[1]) - diff_t'(sx_reg[0]);
        dy_l    = diff_t'(sy_reg[1]) - diff_t'(sy_reg[0]);
        dx_r    = diff_t'(sx_reg[2]) - diff_t'(sx_reg[0]);
        dy_r    = diff_t'(sy_reg[2]) - diff_t'(sy_reg[0]);
        if (kind_reg == KIND_FLAT_TOP) begin
            dx_l   = diff_t'(sx_reg[2]) - diff_t'(sx_reg[0]);
            dy_l   = diff_t'(sy_reg[2]) - diff_t'(sy_reg[0]);
            dx_r   = diff_t'(sx_reg[2]) - diff_t'(sx_reg[1]);
            base_r = sx_reg[1];
        end else if (kind_reg == KIND_FLAT_BOTTOM) begin
            dy_r   = diff_t'(sy_reg[1]) - diff_t'(sy_reg[0]);
        end else if (y1_clip) begin
            // top clip lies below the middle vertex
            dx_l   = diff_t'(sx_reg[2]) - diff_t'(sx_reg[1]);
            dy_l   = diff_t'(sy_reg[2]) - diff_t'(sy_reg[1]);
            base_l = sx_reg[1];
            dd_l   = mny - diff_t'(sy_reg[1]);
        end
        d_l  = dd_l[COORD_BITS-1:0];
        d_r  = dd_r[COORD_BITS-1:0];
        ys   = y0_clip ? coord_t'(mny) : sy_reg[0];
        swap = general && (y1_clip ? (slope_r_reg > slope_l_reg)
                                   : (slope_r_reg < slope_l_reg));
    end

    // Span x from rounded edges, clipped
    always_comb begin
        sum_l = sx_t'(edge_l_reg) + ROUND_HALF;
        sum_r = sx_t'(edge_r_reg) + ROUND_HALF;
        xs    = sum_l >>> FRAC_BITS;
        xe    = sum_r >>> FRAC_BITS;
        if (xs < sx_t'({1'b0, clip_min_x_reg})) begin
            xs = sx_t'({1'b0, clip_min_x_reg});
        end
        if (xe > sx_t'({1'b0, clip_max_x_reg})) begin
            xe = sx_t'({1'b0, clip_max_x_reg});
        end
        next_line = diff_t'(cur_line_reg) + diff_t'(1);
    end

    // Shared multiplier operand select
    always_comb begin
        mul_a = slope_l_reg;
        mul_b = d_l;
        case (state_reg)
            S_MUL_R: begin
                mul_a = slope_r_reg;
                mul_b = d_r;
            end
            S_MUL_A: begin
                mul_a = edge_t'(line_pitch_reg);
                mul_b = ys;
            end
            default: ;
        endcase
        mul_full = mul_a * $signed({1'b0, mul_b});
    end

    // Divider request select
    always_comb begin
        div_req.start = (state_reg == S_DIV_L) || (state_reg == S_DIV_R) ||
                        (state_reg == S_REST_DIV);
        div_req.dx = dx_l;
        div_req.dy = dy_l;
        case (state_reg)
            S_DIV_R: begin
                div_req.dx = dx_r;
                div_req.dy = dy_r;
            end
            S_REST_DIV: begin
                div_req.dx = diff_t'(sx_reg[2]) - diff_t'(sx_reg[1]);
                div_req.dy = diff_t'(sy_reg[2]) - diff_t'(sy_reg[1]);
            end
            default: ;
        endcase
    end

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        kind_next      = kind_reg;
        color_next     = color_reg;
        edge_l_next    = edge_l_reg;
        edge_r_next    = edge_r_reg;
        slope_l_next   = slope_l_reg;
        slope_r_next   = slope_r_reg;
        cur_line_next  = cur_line_reg;
        end_line_next  = end_line_reg;
        right_next     = right_reg;
        armed_next     = armed_reg;
        busy_next      = busy_reg;
        line_addr_next = line_addr_reg;
        prod_next      = prod_reg;
        result_next    = result_reg;
        s_ready        = (state_reg == S_IDLE);
        m_valid        = (state_reg == S_RESP);

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    result_next = '0;
                    if (s_data.command == CMD_LOAD) begin
                        sx_next    = vx;
                        sy_next    = vy;
                        kind_next  = kind_in;
                        color_next = s_data.fill_color;
                        busy_next  = 1'b0;
                        armed_next = 1'b0;
                        right_next = 1'b0;
                        if (reject || degenerate) begin
                            result_next.status = STATUS_NOTHING;
                            state_next = S_RESP;
                        end else begin
                            state_next = S_DIV_L;
                        end
                    end else if (!busy_reg) begin
                        result_next.status = STATUS_IDLE;
                        state_next = S_RESP;
                    end else begin
                        // emit span, then step edges
                        result_next.status      = STATUS_SPAN;
                        result_next.span_y      = cur_line_reg;
                        result_next.x_start     = xs[COORD_BITS-1:0];
                        result_next.x_end       = xe[COORD_BITS-1:0];
                        result_next.row_address = line_addr_reg;
                        result_next.span_color  = color_reg;
                        edge_l_next    = edge_l_reg + slope_l_reg;
                        edge_r_next    = edge_r_reg + slope_r_reg;
                        cur_line_next  = next_line[COORD_BITS-1:0];
                        line_addr_next = line_addr_reg + word_t'(line_pitch_reg);
                        if (next_line >= diff_t'(end_line_reg)) begin
                            busy_next = 1'b0;
                            result_next.last_span = 1'b1;
                        end
                        if (armed_reg && cur_line_reg == sy_reg[1]) begin
                            state_next = S_REST_DIV;
                        end else begin
                            state_next = S_RESP;
                        end
                    end
                end
            end
            S_DIV_L: state_next = S_WAIT_L;
            S_WAIT_L: begin
                if (div_rsp.done) begin
                    slope_l_next = div_rsp.quo;
                    state_next   = S_DIV_R;
                end
            end
            S_DIV_R: state_next = S_WAIT_R;
            S_WAIT_R: begin
                if (div_rsp.done) begin
                    slope_r_next = div_rsp.quo;
                    state_next   = S_MUL_L;
                end
            end
            S_MUL_L: begin
                prod_next  = mul_full[EDGE_W-1:0];
                state_next = S_ADD_L;
            end
            S_ADD_L: begin
                edge_l_next = prod_reg + fix(base_l);
                state_next  = S_MUL_R;
            end
            S_MUL_R: begin
                prod_next  = mul_full[EDGE_W-1:0];
                state_next = S_ADD_R;
            end
            S_ADD_R: begin
                edge_r_next = prod_reg + fix(base_r);
                state_next  = S_MUL_A;
            end
            S_MUL_A: begin
                prod_next  = mul_full[EDGE_W-1:0];
                state_next = S_FINISH;
            end
            S_FINISH: begin
                // left/right swap for a general triangle, then line range
                if (swap) begin
                    slope_l_next = slope_r_reg;
                    slope_r_next = slope_l_reg;
                    edge_l_next  = edge_r_reg;
                    edge_r_next  = edge_l_reg;
                    right_next   = 1'b1;
                end
                armed_next     = general;
                end_line_next  = (diff_t'(sy_reg[2]) > mxy) ? coord_t'(mxy) : sy_reg[2];
                cur_line_next  = ys;
                line_addr_next = frame_base_reg + word_t'(prod_reg);
                if (ys >= end_line_next) begin
                    result_next.status = STATUS_NOTHING;
                end else begin
                    result_next.status = STATUS_ACCEPTED;
                    busy_next = 1'b1;
                end
                state_next = S_RESP;
            end
            S_REST_DIV: state_next = S_REST_WAIT;
            S_REST_WAIT: begin
                // middle vertex reached: new edge from middle to bottom
                if (div_rsp.done) begin
                    if (right_reg) begin
                        slope_r_next = div_rsp.quo;
                        edge_r_next  = fix(sx_reg[1]) + div_rsp.quo;
                    end else begin
                        slope_l_next = div_rsp.quo;
                        edge_l_next  = fix(sx_reg[1]) + div_rsp.quo;
                    end
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign m_data = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            armed_reg <= 1'b0;
            right_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            armed_reg <= armed_next;
            right_reg <= right_next;
        end
        sx_reg        <= sx_next;
        sy_reg        <= sy_next;
        kind_reg      <= kind_next;
        color_reg     <= color_next;
        edge_l_reg    <= edge_l_next;
        edge_r_reg    <= edge_r_next;
        slope_l_reg   <= slope_l_next;
        slope_r_reg   <= slope_r_next;
        cur_line_reg  <= cur_line_next;
        end_line_reg  <= end_line_next;
        line_addr_reg <= line_addr_next;
        prod_reg      <= prod_next;
        result_reg    <= result_next;
    end

endmodule

>>> rtl/core/fptsg_checker.sv
// Port-level checks for the triangle span generator, bound to the top.
// Depends on fptsg_pkg and fixed_point_triangle_span_generator_assert.svh.
`include "fixed_point_triangle_span_generator_assert.svh"

module fptsg_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input fptsg_pkg::out_item_t m_data
);
    import fptsg_pkg::*;

    // stalled result holds
    `FPTSG_ASSERT(a_result_hold, m_valid && !m_ready |=> m_valid && $stable(m_data))
    // one request in flight: no intake while a result waits
    `FPTSG_ASSERT(a_no_overlap, m_valid |-> !s_ready)
    // an accepted request closes intake
    `FPTSG_ASSERT(a_take_closes, s_valid && s_ready |=> !s_ready)
    // only spans carry span fields
    `FPTSG_ASSERT(a_nonspan_clean, m_valid && m_data.status != STATUS_SPAN |-> !m_data.last_span && m_data.x_start == '0)

endmodule

bind fixed_point_triangle_span_generator fptsg_checker u_fptsg_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

>>> test/fixed_point_triangle_span_generator_tb.sv
// Self-checking testbench for the triangle span generator.
// Depends on fptsg_pkg and the fixed_point_triangle_span_generator RTL.
module fixed_point_triangle_span_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fptsg_pkg::*;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0] cfg_data = '0;

    fixed_point_triangle_span_generator uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Shadow registers and edge-walk state
    longint clip_lo_x, clip_hi_x, clip_lo_y, clip_hi_y;
    logic [31:0] base_addr;
    logic [15:0] pitch;
    longint edge_l, edge_r, slope_l, slope_r;
    longint cur_line, stop_line, bend_line;
    bit bend_right, bend_armed, drawing;
    longint tri_v[6];
    logic [31:0] tri_color, row_addr;

    out_item_t expected_spans[$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit drain_each = 0;
    int sent_count = 0;
    bit failed = 0;

    function automatic longint wrap32(longint v);
        int t;
        t = v[31:0];
        return t;
    endfunction

    function automatic longint edge_slope(longint dx, longint dy);
        if (dy <= 0) return 0;
        return wrap32((dx * 65536) / dy);
    endfunction

    // Triangle setup; returns the load status
    function automatic status_t setup_triangle(in_item_t it);
        longint vx[3], vy[3];
        longint x0, y0, x1, y1, x2, y2, sl, sr, el, er, ys, rx, d, tmp;
        int a, b, c, t, kind;
        bit swap;
        vx[0] = it.vert_a_x; vy[0] = it.vert_a_y;
        vx[1] = it.vert_b_x; vy[1] = it.vert_b_y;
        vx[2] = it.vert_c_x; vy[2] = it.vert_c_y;
        a = 0; b = 1; c = 2;
        drawing = 0; bend_armed = 0; bend_right = 0;
        tri_color = it.fill_color;
        // trivial reject against the clip rectangle
        if ((vy[0] < clip_lo_y && vy[1] < clip_lo_y && vy[2] < clip_lo_y) ||
            (vy[0] > clip_hi_y && vy[1] > clip_hi_y && vy[2] > clip_hi_y) ||
            (vx[0] < clip_lo_x && vx[1] < clip_lo_x && vx[2] < clip_lo_x) ||
            (vx[0] > clip_hi_x && vx[1] > clip_hi_x && vx[2] > clip_hi_x))
            return STATUS_NOTHING;
        if (vy[b] < vy[a]) begin t = a; a = b; b = t; end
        if (vy[c] < vy[a]) begin t = a; a = c; c = t; end
        if (vy[c] < vy[b]) begin t = b; b = c; c = t; end
        if (vy[a] == vy[b]) begin
            kind = 0;
            if (vx[b] < vx[a]) begin t = a; a = b; b = t; end
        end else if (vy[b] == vy[c]) begin
            kind = 1;
            if (vx[c] < vx[b]) begin t = b; b = c; c = t; end
        end else begin
            kind = 2;
        end
        x0 = vx[a]; y0 = vy[a]; x1 = vx[b]; y1 = vy[b]; x2 = vx[c]; y2 = vy[c];
        tri_v[0] = x0; tri_v[1] = y0; tri_v[2] = x1;
        tri_v[3] = y1; tri_v[4] = x2; tri_v[5] = y2;
        if ((x0 == x1 && x1 == x2) || (y0 == y1 && y1 == y2))
            return STATUS_NOTHING;
        bend_line = y1;
        if (kind != 2) begin
            rx = (kind == 0) ? x1 : x0;
            if (kind == 0) begin
                sl = edge_slope(x2 - x0, y2 - y0);
                sr = edge_slope(x2 - x1, y2 - y0);
            end else begin
                sl = edge_slope(x1 - x0, y1 - y0);
                sr = edge_slope(x2 - x0, y1 - y0);
            end
            // pre-step when the top is clipped
            d = (y0 < clip_lo_y) ? clip_lo_y - y0 : 0;
            el = sl * d + x0 * 65536;
            er = sr * d + rx * 65536;
            ys = y0 + d;
        end else begin
            bend_armed = 1;
            if (y1 < clip_lo_y) begin
                sl = edge_slope(x2 - x1, y2 - y1);
                sr = edge_slope(x2 - x0, y2 - y0);
                el = sl * (clip_lo_y - y1) + x1 * 65536;
                er = sr * (clip_lo_y - y0) + x0 * 65536;
                ys = clip_lo_y;
                swap = sr > sl;
            end else begin
                d = (y0 < clip_lo_y) ? clip_lo_y - y0 : 0;
                sl = edge_slope(x1 - x0, y1 - y0);
                sr = edge_slope(x2 - x0, y2 - y0);
                el = sl * d + x0 * 65536;
                er = sr * d + x0 * 65536;
                ys = y0 + d;
                swap = sr < sl;
            end
            if (swap) begin
                tmp = sl; sl = sr; sr = tmp;
                tmp = el; el = er; er = tmp;
                bend_right = 1;
            end
        end
        slope_l = sl; slope_r = sr;
        edge_l = wrap32(el); edge_r = wrap32(er);
        stop_line = (y2 > clip_hi_y) ? clip_hi_y : y2;
        cur_line = ys;
        row_addr = base_addr + 32'(ys) * 32'(pitch);
        if (ys >= stop_line) return STATUS_NOTHING;
        drawing = 1;
        return STATUS_ACCEPTED;
    endfunction

    // Expected result of one request; advances the shadow state
    function automatic out_item_t next_result(in_item_t it);
        out_item_t r;
        longint xs, xe, s;
        r = '0;
        r.status = STATUS_IDLE;
        if (it.command == CMD_LOAD) begin
            r.status = setup_triangle(it);
            return r;
        end
        if (!drawing) return r;
        xs = (edge_l + 32768) >>> 16;
        xe = (edge_r + 32768) >>> 16;
        if (xs < clip_lo_x) xs = clip_lo_x;
        if (xe > clip_hi_x) xe = clip_hi_x;
        r.status = STATUS_SPAN;
        r.span_y = coord_t'(cur_line);
        r.x_start = coord_t'(xs);
        r.x_end = coord_t'(xe);
        r.row_address = row_addr;
        r.span_color = tri_color;
        edge_l = wrap32(edge_l + slope_l);
        edge_r = wrap32(edge_r + slope_r);
        // switch to the middle-to-bottom edge after the middle line
        if (bend_armed && cur_line == bend_line) begin
            s = edge_slope(tri_v[4] - tri_v[2], tri_v[5] - tri_v[3]);
            if (bend_right) begin
                slope_r = s; edge_r = wrap32(tri_v[2] * 65536 + s);
            end else begin
                slope_l = s; edge_l = wrap32(tri_v[2] * 65536 + s);
            end
        end
        cur_line++;
        row_addr = row_addr + 32'(pitch);
        if (cur_line >= stop_line) begin
            drawing = 0;
            r.last_span = 1'b1;
        end
        return r;
    endfunction

    // Send one request, predicting its result at acceptance
    task automatic send_request(in_item_t it);
        if (drain_each && expected_spans.size() != 0) begin
            s_valid <= 1'b0;
            while (expected_spans.size() != 0) @(posedge aclk);
        end
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        expected_spans.push_back(next_result(it));
        sent_count++;
    endtask

    task automatic load_tri(int ax, int ay, int bx, int by, int cx, int cy,
                            logic [31:0] color);
        in_item_t it;
        it = '0;
        it.command = CMD_LOAD;
        it.vert_a_x = coord_t'(ax); it.vert_a_y = coord_t'(ay);
        it.vert_b_x = coord_t'(bx); it.vert_b_y = coord_t'(by);
        it.vert_c_x = coord_t'(cx); it.vert_c_y = coord_t'(cy);
        it.fill_color = color;
        send_request(it);
    endtask

    // Span request; unused fields carry random noise
    task automatic span_req();
        in_item_t it;
        it = in_item_t'({$urandom, $urandom, $urandom});
        it.command = CMD_SPAN;
        send_request(it);
    endtask

    task automatic spans_until_done(int cap);
        int n;
        n = 0;
        while (drawing && n < cap) begin
            span_req();
            n++;
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_spans.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_CLIP_MIN_X: clip_lo_x = value[10:0];
            CFG_CLIP_MAX_X: clip_hi_x = value[10:0];
            CFG_CLIP_MIN_Y: clip_lo_y = value[10:0];
            CFG_CLIP_MAX_Y: clip_hi_y = value[10:0];
            CFG_FRAME_BASE: base_addr = value;
            CFG_LINE_PITCH: pitch = value[15:0];
            default: ;
        endcase
    endtask

    task automatic set_clip(int x0, int x1, int y0, int y1, logic [31:0] fb,
                            logic [15:0] lp);
        wait_idle();
        write_reg(CFG_CLIP_MIN_X, x0);
        write_reg(CFG_CLIP_MAX_X, x1);
        write_reg(CFG_CLIP_MIN_Y, y0);
        write_reg(CFG_CLIP_MAX_Y, y1);
        write_reg(CFG_FRAME_BASE, fb);
        write_reg(CFG_LINE_PITCH, lp);
        cfg_valid <= 1'b0;
    endtask

    function automatic int near(longint lo, longint hi);
        int v;
        v = int'(lo) - 30 + $urandom_range(int'(hi - lo) + 60 > 0 ?
                                            int'(hi - lo) + 60 : 60);
        if (v > 2047) v = 2047;
        if (v < -2048) v = -2048;
        return v;
    endfunction

    function automatic int jitter(int v, int spread);
        int r;
        r = v + $urandom_range(2 * spread) - spread;
        if (r > 2047) r = 2047;
        if (r < -2048) r = -2048;
        return r;
    endfunction

    // Directed corner cases with the reset clip rectangle
    task automatic test_directed();
        span_req();                                          // idle span
        load_tri(0, 0, 10, 0, 5, 8, 32'h0000_0000);          // flat top
        spans_until_done(20);
        load_tri(20, 5, 10, 12, 30, 12, 32'hFFFF_FFFF);      // flat bottom
        spans_until_done(20);
        load_tri(100, 10, 90, 14, 110, 20, 32'h00AB_CDEF);   // bend on left
        spans_until_done(20);
        load_tri(100, 10, 115, 14, 95, 20, 32'h0012_3456);   // bend on right
        spans_until_done(20);
        load_tri(50, -6, 40, -2, 60, 5, 32'h5A5A_5A5A);      // middle above clip
        spans_until_done(20);
        load_tri(-5, 630, 650, 470, 300, 490, 32'hA5A5_A5A5); // clipped left, right, bottom
        span_req(); span_req();
        load_tri(-2048, -2048, 2047, 2047, -2048, 2047, 32'h8000_0001);
        span_req();                                          // abandon mid-walk
        load_tri(3, 3, 3, 9, 3, 20, 32'h1);                  // collinear x
        load_tri(1, 7, 9, 7, 40, 7, 32'h2);                  // all on one line
        load_tri(-9, 5, -3, 9, -1, 20, 32'h3);               // left of clip
        load_tri(700, 5, 800, 9, 900, 20, 32'h4);            // right of clip
        span_req();
    endtask

    // Random triangles near the clip window, a few across the whole field
    task automatic test_random(int n_items);
        int goal, ax, ay, nsp;
        in_item_t it;
        goal = sent_count + n_items;
        while (sent_count < goal) begin
            case ($urandom_range(9))
                0: begin
                    it = in_item_t'({$urandom, $urandom, $urandom});
                    it.command = CMD_LOAD;
                    send_request(it);
                end
                1: span_req();
                default: begin
                    ax = near(clip_lo_x, clip_hi_x);
                    ay = near(clip_lo_y, clip_hi_y);
                    load_tri(ax, ay, jitter(ax, 40), jitter(ay, 20),
                             jitter(ax, 40), jitter(ay, 20), $urandom);
                end
            endcase
            nsp = ($urandom_range(3) == 0) ? $urandom_range(4) : 40;
            spans_until_done(nsp);
        end
    endtask

    // Bend on the middle line with a drained pipeline before each request
    task automatic test_drained();
        drain_each = 1;
        load_tri(200, 100, 180, 106, 230, 112, $urandom);
        spans_until_done(20);
        drain_each = 0;
    endtask

    // Result checking
    always @(posedge aclk) begin
        out_item_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
            if (m_valid && m_ready) begin
                if (expected_spans.size() == 0) begin
                    $error("unexpected result %p", m_data);
                    failed = 1;
                end else begin
                    e = expected_spans.pop_front();
                    if (m_data.status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, m_data.status);
                        failed = 1;
                    end
                    if (m_data.span_y !== e.span_y) begin
                        $error("span_y exp %0d got %0d", e.span_y, m_data.span_y);
                        failed = 1;
                    end
                    if (m_data.x_start !== e.x_start) begin
                        $error("x_start exp %0d got %0d", e.x_start, m_data.x_start);
                        failed = 1;
                    end
                    if (m_data.x_end !== e.x_end) begin
                        $error("x_end exp %0d got %0d", e.x_end, m_data.x_end);
                        failed = 1;
                    end
                    if (m_data.row_address !== e.row_address) begin
                        $error("row_address exp %h got %h", e.row_address,
                               m_data.row_address);
                        failed = 1;
                    end
                    if (m_data.span_color !== e.span_color) begin
                        $error("span_color exp %h got %h", e.span_color,
                               m_data.span_color);
                        failed = 1;
                    end
                    if (m_data.last_span !== e.last_span) begin
                        $error("last_span exp %0d got %0d", e.last_span,
                               m_data.last_span);
                        failed = 1;
                    end
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("FAIL fixed_point_triangle_span_generator");
        $finish;
    end

    initial begin
        clip_lo_x = 0; clip_hi_x = 639; clip_lo_y = 0; clip_hi_y = 479;
        base_addr = 0; pitch = 640;
        edge_l = 0; edge_r = 0; slope_l = 0; slope_r = 0;
        cur_line = 0; stop_line = 0; bend_line = 0;
        bend_right = 0; bend_armed = 0; drawing = 0;
        tri_color = 0; row_addr = 0;
        foreach (tri_v[i]) tri_v[i] = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sender idles lightly, receiver heavily
        send_idle_pct = 9; recv_idle_pct = 67;
        test_directed();
        test_drained();
        test_random(450);

        // full clip window, wrapping row addresses
        send_idle_pct = 67; recv_idle_pct = 9;
        set_clip(0, 2047, 0, 2047, 32'hFFFF_FFF0, 16'hFFFF);
        test_random(450);

        // no idling, narrow window and zero pitch
        send_idle_pct = 0; recv_idle_pct = 0;
        set_clip(100, 300, 50, 200, $urandom, 16'h0000);
        test_random(450);

        // inverted clip rectangle
        set_clip(600, 100, 300, 50, 32'h0, 16'd1);
        test_random(150);

        wait_idle();
        repeat (40) @(posedge aclk);
        if (!failed && expected_spans.size() == 0) begin
            $display("PASS fixed_point_triangle_span_generator");
        end else begin
            $display("FAIL fixed_point_triangle_span_generator");
        end
        $finish;
    end
endmodule

>>> fixed_point_triangle_span_generator.f
+incdir+rtl/core
rtl/core/fptsg_pkg.sv
rtl/core/fptsg_divider.sv
rtl/core/fixed_point_triangle_span_generator.sv
rtl/core/fptsg_checker.sv
test/fixed_point_triangle_span_generator_tb.sv
